// ===== design/sfua_pkg.sv =====
// Shared constants and types for the serial frame unpack / average block.
// Used by the top level, the sum RAM sizing and the port checker; no dependencies.
package sfua_pkg;

    // Frame layout
    localparam int CHANNEL_COUNT = 32;
    localparam int WORD_BITS     = 20;
    localparam int MAX_AVERAGE   = 1024;
    localparam int FRAME_BYTES   = (CHANNEL_COUNT * WORD_BITS + 7) / 8;

    // Fixed port and register widths
    localparam int BYTE_W        = 8;
    localparam int CH_OUT_BITS   = 5;
    localparam int COUNT_BITS    = 11;
    localparam int FRAME_BITS    = 10;
    localparam int PDATA_BITS    = 32;
    localparam int PADDR_BITS    = 3;

    // Derived widths
    localparam int BUF_BITS      = WORD_BITS + BYTE_W - 1;
    localparam int HELD_BITS     = $clog2(BUF_BITS + 1);
    localparam int BYTE_IDX_BITS = $clog2(FRAME_BYTES + 1);
    localparam int CH_IDX_BITS   = $clog2(CHANNEL_COUNT + 1);
    localparam int CH_ADDR_BITS  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int DIV_BITS      = $clog2(MAX_AVERAGE + 1);
    localparam int SUM_BITS      = WORD_BITS + $clog2(MAX_AVERAGE);

    // Divider: two quotient bits per cycle
    localparam int DIV_STEPS     = 2;
    localparam int DIV_CYCLES    = (SUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QUO_BITS      = DIV_CYCLES * DIV_STEPS;
    localparam int STEP_BITS     = $clog2(DIV_CYCLES + 1);

    // Register map (index taken from paddr[2])
    localparam logic REG_AVG_COUNT = 1'b0;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [SUM_BITS-1:0]  t_sum;
    typedef logic [DIV_BITS-1:0]  t_count;

endpackage

// ===== design/sfua_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; sized by WIDTH and DEPTH parameters.
module sfua_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/serial_frame_unpack_average.sv =====
// Top level: byte-serial frame unpacker with per-channel block averaging.
// Depends on sfua_pkg and sfua_ram (per-channel sum storage).

// Bytes enter MSB first through start/busy: a request is taken on a clock edge
// with start high and busy low. Each 80-byte frame carries 32 packed 20-bit
// channel words. A byte that completes no word is absorbed in its accept cycle
// and busy stays low. A byte that completes a word reads that channel's sum from
// a registered-read RAM at accept, and writes the updated sum back in the
// following cycle (busy high for 1 cycle). On the final frame of a group the
// sum is then divided by the effective count in a radix-4 restoring divider,
// busy staying high throughout, and the result strobe (o_result_valid, with
// o_channel, o_average, o_last) appears for one cycle, in the cycle in which
// busy is low again. The next request can be taken at the end of that cycle.
// Results cannot be held off: the receiver must take each strobe as it comes.
// average_count is an APB register at address 0 (0 is treated as 1, values
// above 1024 as 1024); write it only while idle. The sum RAM needs no
// clearing: the first frame of a group overwrites every channel before any
// read uses it.
module serial_frame_unpack_average
    import sfua_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     start,
    output logic                     busy,
    input  logic [BYTE_W-1:0]        i_data_byte,
    input  logic                     i_group_start,
    // result channel
    output logic                     o_result_valid,
    output logic [CH_OUT_BITS-1:0]   o_channel,
    output logic [WORD_BITS-1:0]     o_average,
    output logic                     o_last,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_BITS-1:0]    paddr,
    input  logic [PDATA_BITS-1:0]    pwdata,
    output logic [PDATA_BITS-1:0]    prdata,
    output logic                     pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // ---------------- control state ----------------
    logic [1:0]               r_state,       n_state;
    logic [BUF_BITS-1:0]      r_bit_buffer,  n_bit_buffer;
    logic [HELD_BITS-1:0]     r_bits_held,   n_bits_held;
    logic [BYTE_IDX_BITS-1:0] r_byte_index,  n_byte_index;
    logic [CH_IDX_BITS-1:0]   r_channel_idx, n_channel_idx;
    logic [FRAME_BITS-1:0]    r_frame,       n_frame;
    logic [COUNT_BITS-1:0]    r_avg_count;
    logic [STEP_BITS-1:0]     r_step,        n_step;
    logic                     r_result_valid, n_result_valid;

    // ---------------- per-word payload ----------------
    t_word                    r_word,  n_word;
    logic [CH_ADDR_BITS-1:0]  r_wch,   n_wch;
    logic                     r_first, n_first;
    logic                     r_final, n_final;
    t_count                   r_count, n_count;

    // divider
    logic [DIV_BITS-1:0]      r_rem,   n_rem;
    logic [QUO_BITS-1:0]      r_quo,   n_quo;

    // result registers
    logic [CH_OUT_BITS-1:0]   r_out_ch,  n_out_ch;
    t_word                    r_out_avg, n_out_avg;
    logic                     r_out_last, n_out_last;

    // ---------------- front end (valid in accept cycle) ----------------
    logic                     w_accept;
    logic [BUF_BITS-1:0]      c_buf;
    logic [HELD_BITS-1:0]     c_held;
    logic [BYTE_IDX_BITS-1:0] c_byte;
    logic [CH_IDX_BITS-1:0]   c_ch;
    logic [FRAME_BITS-1:0]    c_frame;
    t_count                   c_count;
    logic                     c_final;
    logic [BUF_BITS-1:0]      c_shift;
    logic [HELD_BITS-1:0]     c_held8;
    logic [HELD_BITS-1:0]     c_rest;
    logic                     c_room;
    logic                     c_word_done;
    t_word                    c_word;
    logic [BYTE_IDX_BITS-1:0] c_byte1;

    // RAM side
    t_sum                     w_rdata;
    t_sum                     w_sum;
    logic                     w_we;

    // divider
    logic [DIV_BITS-1:0]      w_rem2;
    logic [QUO_BITS-1:0]      w_quo2;

    logic                     w_cfg_wr;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);

    // Resync: group_start restarts the frame before the byte goes in.
    always_comb begin
        c_buf   = i_group_start ? '0 : r_bit_buffer;
        c_held  = i_group_start ? '0 : r_bits_held;
        c_byte  = i_group_start ? '0 : r_byte_index;
        c_ch    = i_group_start ? '0 : r_channel_idx;
        c_frame = i_group_start ? '0 : r_frame;

        if (r_avg_count == '0) begin
            c_count = t_count'(1);
        end else if (32'(r_avg_count) > MAX_AVERAGE) begin
            c_count = t_count'(MAX_AVERAGE);
        end else begin
            c_count = t_count'(r_avg_count);
        end
        c_final = (32'(c_frame) + 32'd1) >= 32'(c_count);

        c_shift     = {c_buf[BUF_BITS-BYTE_W-1:0], i_data_byte};
        c_held8     = c_held + HELD_BITS'(BYTE_W);
        c_rest      = c_held8 - HELD_BITS'(WORD_BITS);
        c_room      = 32'(c_ch) < CHANNEL_COUNT;
        c_word_done = c_room && (32'(c_held8) >= WORD_BITS);
        c_word      = t_word'(c_shift >> c_rest);
        c_byte1     = c_byte + BYTE_IDX_BITS'(1);
    end

    // Two restoring-division steps per cycle.
    function automatic logic [DIV_BITS+QUO_BITS-1:0] div_steps(
        input logic [DIV_BITS-1:0] rem,
        input logic [QUO_BITS-1:0] quo,
        input t_count              dvs
    );
        logic [DIV_BITS:0]   t;
        logic [DIV_BITS-1:0] r;
        logic [QUO_BITS-1:0] q;
        r = rem;
        q = quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {r, q[QUO_BITS-1]};
            if (t >= {1'b0, dvs}) begin
                t = t - {1'b0, dvs};
                q = {q[QUO_BITS-2:0], 1'b1};
            end else begin
                q = {q[QUO_BITS-2:0], 1'b0};
            end
            r = t[DIV_BITS-1:0];
        end
        return {r, q};
    endfunction

    assign {w_rem2, w_quo2} = div_steps(r_rem, r_quo, r_count);

    // Read-modify-write of the channel sum; first frame overwrites.
    assign w_sum = r_first ? t_sum'(r_word) : (w_rdata + t_sum'(r_word));
    assign w_we  = (r_state == S_UPD);

    always_comb begin
        n_state        = r_state;
        n_bit_buffer   = r_bit_buffer;
        n_bits_held    = r_bits_held;
        n_byte_index   = r_byte_index;
        n_channel_idx  = r_channel_idx;
        n_frame        = r_frame;
        n_step         = r_step;
        n_result_valid = 1'b0;
        n_word         = r_word;
        n_wch          = r_wch;
        n_first        = r_first;
        n_final        = r_final;
        n_count        = r_count;
        n_rem          = r_rem;
        n_quo          = r_quo;
        n_out_ch       = r_out_ch;
        n_out_avg      = r_out_avg;
        n_out_last     = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bit_buffer  = c_buf;
                    n_bits_held   = c_held;
                    n_channel_idx = c_ch;
                    if (c_word_done) begin
                        n_bit_buffer  = c_shift & ~({BUF_BITS{1'b1}} << c_rest);
                        n_bits_held   = c_rest;
                        n_channel_idx = c_ch + CH_IDX_BITS'(1);
                        n_word        = c_word;
                        n_wch         = c_ch[CH_ADDR_BITS-1:0];
                        n_first       = (c_frame == '0);
                        n_final       = c_final;
                        n_count       = c_count;
                        n_state       = S_UPD;
                    end else if (c_room) begin
                        n_bit_buffer  = c_shift;
                        n_bits_held   = c_held8;
                    end
                    // frame boundary: trailing bits dropped, group may wrap
                    if (32'(c_byte1) >= FRAME_BYTES) begin
                        n_bit_buffer  = '0;
                        n_bits_held   = '0;
                        n_byte_index  = '0;
                        n_channel_idx = '0;
                        n_frame       = c_final ? '0 : c_frame + FRAME_BITS'(1);
                    end else begin
                        n_byte_index  = c_byte1;
                        n_frame       = c_frame;
                    end
                end
            end
            S_UPD: begin
                if (r_final) begin
                    n_rem   = '0;
                    n_quo   = QUO_BITS'(w_sum);
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                n_rem  = w_rem2;
                n_quo  = w_quo2;
                n_step = r_step + STEP_BITS'(1);
                if (32'(r_step) == DIV_CYCLES - 1) begin
                    // saturate quotient to the word range
                    if (w_quo2[QUO_BITS-1:WORD_BITS] != '0) begin
                        n_out_avg = '1;
                    end else begin
                        n_out_avg = w_quo2[WORD_BITS-1:0];
                    end
                    n_out_ch       = CH_OUT_BITS'(r_wch);
                    n_out_last     = (32'(r_wch) == CHANNEL_COUNT - 1);
                    n_result_valid = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bit_buffer   <= '0;
            r_bits_held    <= '0;
            r_byte_index   <= '0;
            r_channel_idx  <= '0;
            r_frame        <= '0;
            r_step         <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_bit_buffer   <= n_bit_buffer;
            r_bits_held    <= n_bits_held;
            r_byte_index   <= n_byte_index;
            r_channel_idx  <= n_channel_idx;
            r_frame        <= n_frame;
            r_step         <= n_step;
            r_result_valid <= n_result_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word     <= n_word;
        r_wch      <= n_wch;
        r_first    <= n_first;
        r_final    <= n_final;
        r_count    <= n_count;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_out_ch   <= n_out_ch;
        r_out_avg  <= n_out_avg;
        r_out_last <= n_out_last;
    end

    // Per-channel sums; read at accept, written back in the following cycle.
    sfua_ram #(
        .WIDTH (SUM_BITS),
        .DEPTH (CHANNEL_COUNT)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wch),
        .i_wdata (w_sum),
        .i_re    (w_accept),
        .i_raddr (c_ch[CH_ADDR_BITS-1:0]),
        .o_rdata (w_rdata)
    );

    // ---------------- configuration ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count <= COUNT_BITS'(1);
        end else if (w_cfg_wr && (paddr[2] == REG_AVG_COUNT)) begin
            r_avg_count <= pwdata[COUNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_AVG_COUNT) ? PDATA_BITS'(r_avg_count) : '0;

    assign o_result_valid = r_result_valid;
    assign o_channel      = r_out_ch;
    assign o_average      = r_out_avg;
    assign o_last         = r_out_last;

endmodule

// ===== design/sfua_checker.sv =====
// Port-level checker for serial_frame_unpack_average, bound to the top level.
// Depends on sfua_pkg for the channel count.
module sfua_checker
    import sfua_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_busy,
    input logic                   i_result_valid,
    input logic [CH_OUT_BITS-1:0] i_channel,
    input logic                   i_last
);

    // results only come out of the divide, so busy was high just before
    a_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |-> $past(i_busy))
        else $error("result strobe without preceding busy");

    // every result needs a fresh request, so strobes never abut
    a_no_abut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_result_valid |=> !i_result_valid)
        else $error("back-to-back result strobes");

    a_last_ch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && i_last) |-> (32'(i_channel) == CHANNEL_COUNT - 1))
        else $error("last flag on wrong channel");

    a_ch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_result_valid && (32'(i_channel) == CHANNEL_COUNT - 1)) |-> i_last)
        else $error("final channel without last flag");

endmodule

bind serial_frame_unpack_average sfua_checker u_sfua_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_busy         (busy),
    .i_result_valid (o_result_valid),
    .i_channel      (o_channel),
    .i_last         (o_last)
);
